// ----- hw/rtl/ptc_pkg.sv -----
// Shared types and constants for the pressure sensor temperature compensation unit.
// Holds the calibration register set, register indexes and the pipeline payload structs.
// No dependencies; every other file of the block imports this package.
package ptc_pkg;

  localparam int CoefW  = 16;
  localparam int RawW   = 24;
  localparam int IdxW   = 3;
  localparam int PressW = 25;
  localparam int TempW  = 19;

  typedef enum logic [IdxW-1:0] {
    REG_SENS        = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_SENS_TEMP   = 3'd2,
    REG_OFFSET_TEMP = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SLOPE  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CoefW-1:0] sens_coef;
    logic [CoefW-1:0] offset_coef;
    logic [CoefW-1:0] sens_temp_coef;
    logic [CoefW-1:0] offset_temp_coef;
    logic [CoefW-1:0] ref_temp_coef;
    logic [CoefW-1:0] temp_slope_coef;
  } cfg_t;

  typedef struct packed {
    logic [RawW-1:0]   d1;
    logic signed [18:0] temp;
    logic signed [39:0] off;
    logic signed [38:0] sens;
    logic [17:0]       ti_cold;
    logic [12:0]       ti_hot;
  } front_t;

  typedef struct packed {
    logic [RawW-1:0]   d1;
    logic signed [41:0] off;
    logic signed [41:0] sens;
    logic signed [19:0] t;
  } corr_t;

  localparam logic signed [18:0] TEMP_REF  = 19'sd2000;
  localparam logic signed [18:0] TEMP_LOW  = -19'sd1500;
  localparam logic signed [PressW-1:0] PRESS_MAX = 25'sh0FFFFFF;
  localparam logic signed [PressW-1:0] PRESS_MIN = 25'sh1000000;
  localparam logic signed [TempW-1:0]  TEMP_MAX  = 19'sh3FFFF;
  localparam logic signed [TempW-1:0]  TEMP_MIN  = 19'sh40000;

endpackage

// ----- hw/rtl/ptc_cfg_regs.sv -----
// Calibration coefficient register file of the compensation unit.
// Depends on ptc_pkg for the register indexes and the cfg_t bundle.
module ptc_cfg_regs import ptc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [CoefW-1:0] cfg_data,
  output cfg_t            cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SENS:        cfg.sens_coef        <= cfg_data;
        REG_OFFSET:      cfg.offset_coef      <= cfg_data;
        REG_SENS_TEMP:   cfg.sens_temp_coef   <= cfg_data;
        REG_OFFSET_TEMP: cfg.offset_temp_coef <= cfg_data;
        REG_REF_TEMP:    cfg.ref_temp_coef    <= cfg_data;
        REG_TEMP_SLOPE:  cfg.temp_slope_coef  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/ptc_front.sv -----
// First-order stages: temperature difference, coefficient products, first-order
// temperature, offset, sensitivity and the squared-difference corrections.
// Depends on ptc_pkg for cfg_t and front_t.
module ptc_front import ptc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  cfg_t           cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [RawW-1:0] raw_pressure,
  input  logic [RawW-1:0] raw_temperature,
  output logic           out_valid,
  input  logic           out_ready,
  output front_t         out_data
);

  logic [2:0] vld;
  logic [2:0] en;

  logic [RawW-1:0]    s1_d1;
  logic signed [24:0] s1_dt;
  logic [RawW-1:0]    s2_d1;
  logic signed [41:0] s2_p_temp;
  logic signed [41:0] s2_p_off;
  logic signed [41:0] s2_p_sens;
  logic [48:0]        s2_dt_sq;

  logic signed [24:0] dt_next;
  logic signed [41:0] p_temp_next;
  logic signed [41:0] p_off_next;
  logic signed [41:0] p_sens_next;
  logic signed [49:0] dt_sq_full;
  logic [50:0]        dt_sq_x3;
  front_t             out_next;

  always_comb begin
    en[2] = ~vld[2] | out_ready;
    en[1] = ~vld[1] | en[2];
    en[0] = ~vld[0] | en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = vld[2];

  assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.ref_temp_coef, 8'h00});

  assign p_temp_next = 42'(s1_dt) * 42'($signed({1'b0, cfg.temp_slope_coef}));
  assign p_off_next  = 42'(s1_dt) * 42'($signed({1'b0, cfg.offset_temp_coef}));
  assign p_sens_next = 42'(s1_dt) * 42'($signed({1'b0, cfg.sens_temp_coef}));
  assign dt_sq_full  = 50'(s1_dt) * 50'(s1_dt);

  assign dt_sq_x3 = {2'b00, s2_dt_sq} + {1'b0, s2_dt_sq, 1'b0};

  always_comb begin
    out_next.d1      = s2_d1;
    out_next.temp    = TEMP_REF + $signed(s2_p_temp[41:23]);
    out_next.off     = 40'($signed({1'b0, cfg.offset_coef, 16'h0000}))
                       + 40'($signed(s2_p_off[41:7]));
    out_next.sens    = 39'($signed({1'b0, cfg.sens_coef, 15'h0000}))
                       + 39'($signed(s2_p_sens[41:8]));
    out_next.ti_cold = dt_sq_x3[50:33];
    out_next.ti_hot  = s2_dt_sq[48:36];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_d1 <= raw_pressure;
      s1_dt <= dt_next;
    end
    if (en[1]) begin
      s2_d1     <= s1_d1;
      s2_p_temp <= p_temp_next;
      s2_p_off  <= p_off_next;
      s2_p_sens <= p_sens_next;
      s2_dt_sq  <= dt_sq_full[48:0];
    end
    if (en[2]) begin
      out_data <= out_next;
    end
  end

endmodule

// ----- hw/rtl/ptc_correct.sv -----
// Second-order correction stages: band selection, squared temperature offsets,
// correction terms and their removal from offset, sensitivity and temperature.
// Depends on ptc_pkg for front_t, corr_t and the band thresholds.
module ptc_correct import ptc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  front_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output corr_t  out_data
);

  logic [2:0] vld;
  logic [2:0] en;

  logic [RawW-1:0]    s1_d1;
  logic signed [39:0] s1_off;
  logic signed [38:0] s1_sens;
  logic signed [19:0] s1_t;
  logic               s1_cold;
  logic               s1_frigid;
  logic [36:0]        s1_dm_sq;
  logic [36:0]        s1_dp_sq;

  logic [RawW-1:0]    s2_d1;
  logic signed [39:0] s2_off;
  logic signed [38:0] s2_sens;
  logic signed [19:0] s2_t;
  logic [40:0]        s2_offi;
  logic [40:0]        s2_sensi;

  logic signed [18:0] dm;
  logic signed [18:0] dp;
  logic signed [37:0] dm_sq_full;
  logic signed [37:0] dp_sq_full;
  logic               cold;
  logic [17:0]        ti_sel;
  logic signed [19:0] t_next;
  logic [38:0]        dm_sq_x3;
  logic [39:0]        dm_sq_x5;
  logic [39:0]        dp_sq_x7;
  logic [40:0]        offi_next;
  logic [40:0]        sensi_next;
  corr_t              out_next;

  always_comb begin
    en[2] = ~vld[2] | out_ready;
    en[1] = ~vld[1] | en[2];
    en[0] = ~vld[0] | en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = vld[2];

  assign dm         = in_data.temp - TEMP_REF;
  assign dp         = in_data.temp - TEMP_LOW;
  assign dm_sq_full = 38'(dm) * 38'(dm);
  assign dp_sq_full = 38'(dp) * 38'(dp);
  assign cold       = in_data.temp < TEMP_REF;
  assign ti_sel     = cold ? in_data.ti_cold : {5'b00000, in_data.ti_hot};
  assign t_next     = 20'(in_data.temp) - 20'($signed({1'b0, ti_sel}));

  assign dm_sq_x3 = {2'b00, s1_dm_sq} + {1'b0, s1_dm_sq, 1'b0};
  assign dm_sq_x5 = {3'b000, s1_dm_sq} + {1'b0, s1_dm_sq, 2'b00};
  assign dp_sq_x7 = {s1_dp_sq, 3'b000} - {3'b000, s1_dp_sq};

  always_comb begin
    if (s1_cold) begin
      offi_next  = {3'b000, dm_sq_x3[38:1]} + (s1_frigid ? {1'b0, dp_sq_x7} : 41'd0);
      sensi_next = {4'b0000, dm_sq_x5[39:3]} + (s1_frigid ? {2'b00, s1_dp_sq, 2'b00} : 41'd0);
    end else begin
      offi_next  = {8'h00, s1_dm_sq[36:4]};
      sensi_next = '0;
    end
  end

  always_comb begin
    out_next.d1   = s2_d1;
    out_next.off  = 42'(s2_off) - $signed({1'b0, s2_offi});
    out_next.sens = 42'(s2_sens) - $signed({1'b0, s2_sensi});
    out_next.t    = s2_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_d1     <= in_data.d1;
      s1_off    <= in_data.off;
      s1_sens   <= in_data.sens;
      s1_t      <= t_next;
      s1_cold   <= cold;
      s1_frigid <= in_data.temp < TEMP_LOW;
      s1_dm_sq  <= dm_sq_full[36:0];
      s1_dp_sq  <= dp_sq_full[36:0];
    end
    if (en[1]) begin
      s2_d1    <= s1_d1;
      s2_off   <= s1_off;
      s2_sens  <= s1_sens;
      s2_t     <= s1_t;
      s2_offi  <= offi_next;
      s2_sensi <= sensi_next;
    end
    if (en[2]) begin
      out_data <= out_next;
    end
  end

endmodule

// ----- hw/rtl/ptc_scale.sv -----
// Pressure scaling stages: split sensitivity product, offset removal, final shift
// and saturation of pressure and temperature into the output register.
// Depends on ptc_pkg for corr_t, field widths and saturation limits.
module ptc_scale import ptc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  corr_t                    in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [PressW-1:0] pressure,
  output logic signed [TempW-1:0]  temperature
);

  logic [3:0] vld;
  logic [3:0] en;

  logic [44:0]        s1_pl;
  logic signed [45:0] s1_ph;
  logic signed [41:0] s1_off;
  logic signed [19:0] s1_t;
  logic signed [46:0] s2_q;
  logic signed [41:0] s2_off;
  logic signed [19:0] s2_t;
  logic signed [34:0] s3_p;
  logic signed [19:0] s3_t;

  logic [44:0]              pl_next;
  logic signed [45:0]       ph_next;
  logic signed [46:0]       q_next;
  logic signed [47:0]       diff;
  logic signed [PressW-1:0] pressure_next;
  logic signed [TempW-1:0]  temperature_next;

  always_comb begin
    en[3] = ~vld[3] | out_ready;
    en[2] = ~vld[2] | en[3];
    en[1] = ~vld[1] | en[2];
    en[0] = ~vld[0] | en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = vld[3];

  // The sensitivity is split at bit 21 so that the upper partial product already
  // carries the weight removed by the shift right by 21.
  assign pl_next = 45'(in_data.d1) * 45'(in_data.sens[20:0]);
  assign ph_next = 46'($signed({1'b0, in_data.d1})) * 46'($signed(in_data.sens[41:21]));
  assign q_next  = 47'(s1_ph) + 47'($signed({1'b0, s1_pl[44:21]}));
  assign diff    = 48'(s2_q) - 48'(s2_off);

  always_comb begin
    if (s3_p > PRESS_MAX) begin
      pressure_next = PRESS_MAX;
    end else if (s3_p < PRESS_MIN) begin
      pressure_next = PRESS_MIN;
    end else begin
      pressure_next = s3_p[PressW-1:0];
    end
    if (s3_t > TEMP_MAX) begin
      temperature_next = TEMP_MAX;
    end else if (s3_t < TEMP_MIN) begin
      temperature_next = TEMP_MIN;
    end else begin
      temperature_next = s3_t[TempW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_pl  <= pl_next;
      s1_ph  <= ph_next;
      s1_off <= in_data.off;
      s1_t   <= in_data.t;
    end
    if (en[1]) begin
      s2_q   <= q_next;
      s2_off <= s1_off;
      s2_t   <= s1_t;
    end
    if (en[2]) begin
      s3_p <= diff[47:13];
      s3_t <= s2_t;
    end
    if (en[3]) begin
      pressure    <= pressure_next;
      temperature <= temperature_next;
    end
  end

endmodule

// ----- hw/rtl/pressure_sensor_temp_compensation_unit.sv -----
// Top level of the pressure sensor second-order temperature compensation unit.
// Depends on ptc_pkg, ptc_cfg_regs, ptc_front, ptc_correct and ptc_scale.
//
// The unit turns one raw pressure and raw temperature request into compensated
// pressure in 0.1 mbar and temperature in 0.01 degC, both saturated to their
// output ranges. It takes one request every cycle unless a stalled output has filled
// the pipeline; each result passes through ten register stages (three first-order
// stages, three correction stages and four scaling stages, where the wide pressure
// product is split in two partial products). A stalled output holds its result, and
// bubbles further up keep filling while it waits. Write the six calibration
// coefficients only while no request is in flight.
module pressure_sensor_temp_compensation_unit import ptc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [IdxW-1:0]          cfg_index,
  input  logic [CoefW-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [RawW-1:0]          raw_pressure,
  input  logic [RawW-1:0]          raw_temperature,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [PressW-1:0] pressure_tenth_mbar,
  output logic signed [TempW-1:0]  temperature_centideg
);

  cfg_t   cfg;
  front_t front_data;
  corr_t  corr_data;
  logic   front_valid;
  logic   front_ready;
  logic   corr_valid;
  logic   corr_ready;

  ptc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ptc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .out_valid       (front_valid),
    .out_ready       (front_ready),
    .out_data        (front_data)
  );

  ptc_correct u_correct (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (corr_valid),
    .out_ready (corr_ready),
    .out_data  (corr_data)
  );

  ptc_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (corr_valid),
    .in_ready    (corr_ready),
    .in_data     (corr_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pressure    (pressure_tenth_mbar),
    .temperature (temperature_centideg)
  );

  // A draining output must let every stage advance, so the input is open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked while the output is being drained");

  // An empty output register cannot hold back the pipeline.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while the output register is empty");

  // The pipeline comes out of reset empty.
  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result presented right after reset");

endmodule

// ----- tb/sv/pressure_sensor_temp_compensation_unit_test.sv -----
// Self-checking testbench for the pressure sensor temperature compensation unit.
// Drives random and directed pressure/temperature requests under several coefficient
// sets and checks every result against its own model; depends on ptc_pkg and the RTL.
import ptc_pkg::*;

typedef struct packed {
  logic signed [PressW-1:0] pressure;
  logic signed [TempW-1:0]  temperature;
} reading_t;

class compensation_scoreboard;
  cfg_t        coefs;
  reading_t    expected_readings[$];
  int unsigned mismatches;

  function new();
    coefs = '0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [IdxW-1:0] idx, logic [CoefW-1:0] value);
    case (idx)
      REG_SENS:        coefs.sens_coef = value;
      REG_OFFSET:      coefs.offset_coef = value;
      REG_SENS_TEMP:   coefs.sens_temp_coef = value;
      REG_OFFSET_TEMP: coefs.offset_temp_coef = value;
      REG_REF_TEMP:    coefs.ref_temp_coef = value;
      REG_TEMP_SLOPE:  coefs.temp_slope_coef = value;
      default: ;
    endcase
  endfunction

  function reading_t compensate(logic [RawW-1:0] d1_raw, logic [RawW-1:0] d2_raw);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, dt_sq, dm, dm_sq, dp, ti, off_corr, sens_corr, p, t;
    reading_t r;
    d1 = d1_raw;
    d2 = d2_raw;
    c1 = coefs.sens_coef;
    c2 = coefs.offset_coef;
    c3 = coefs.sens_temp_coef;
    c4 = coefs.offset_temp_coef;
    c5 = coefs.ref_temp_coef;
    c6 = coefs.temp_slope_coef;
    dt = d2 - c5 * 256;
    temp = longint'(TEMP_REF) + ((dt * c6) >>> 23);
    off = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);
    dt_sq = dt * dt;
    dm = temp - longint'(TEMP_REF);
    dm_sq = dm * dm;
    if (temp < longint'(TEMP_REF)) begin
      ti = (3 * dt_sq) >>> 33;
      off_corr = (3 * dm_sq) >>> 1;
      sens_corr = (5 * dm_sq) >>> 3;
      if (temp < longint'(TEMP_LOW)) begin
        dp = temp - longint'(TEMP_LOW);
        off_corr = off_corr + 7 * dp * dp;
        sens_corr = sens_corr + 4 * dp * dp;
      end
    end else begin
      ti = (2 * dt_sq) >>> 37;
      off_corr = dm_sq >>> 4;
      sens_corr = 0;
    end
    p = (((d1 * (sens - sens_corr)) >>> 21) - (off - off_corr)) >>> 13;
    t = temp - ti;
    if (p > longint'(PRESS_MAX)) p = longint'(PRESS_MAX);
    if (p < longint'(PRESS_MIN)) p = longint'(PRESS_MIN);
    if (t > longint'(TEMP_MAX)) t = longint'(TEMP_MAX);
    if (t < longint'(TEMP_MIN)) t = longint'(TEMP_MIN);
    r.pressure = p[PressW-1:0];
    r.temperature = t[TempW-1:0];
    return r;
  endfunction

  function void note_request(logic [RawW-1:0] d1, logic [RawW-1:0] d2);
    expected_readings.push_back(compensate(d1, d2));
  endfunction

  function void check_result(logic signed [PressW-1:0] p, logic signed [TempW-1:0] t);
    reading_t exp_r;
    if (expected_readings.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: pressure %0d temperature %0d", p, t);
      return;
    end
    exp_r = expected_readings.pop_front();
    if (p !== exp_r.pressure || t !== exp_r.temperature) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: pressure exp %0d got %0d, temperature exp %0d got %0d",
                 exp_r.pressure, p, exp_r.temperature, t);
    end
  endfunction

  function int pending();
    return expected_readings.size();
  endfunction
endclass

module pressure_sensor_temp_compensation_unit_test;

  localparam int LATENCY        = 10;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_BURSTY
  } ready_mode_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [IdxW-1:0]          cfg_index = '0;
  logic [CoefW-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [RawW-1:0]          raw_pressure = '0;
  logic [RawW-1:0]          raw_temperature = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [PressW-1:0] pressure_tenth_mbar;
  logic signed [TempW-1:0]  temperature_centideg;

  compensation_scoreboard sb = new();
  int          burst_left = 0;
  int          idle_cycles = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int          ready_span = 0;

  pressure_sensor_temp_compensation_unit i_dut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .raw_pressure         (raw_pressure),
    .raw_temperature      (raw_temperature),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .pressure_tenth_mbar  (pressure_tenth_mbar),
    .temperature_centideg (temperature_centideg)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_request(raw_pressure, raw_temperature);
      if (out_valid && out_ready)
        sb.check_result(pressure_tenth_mbar, temperature_centideg);
    end
  end

  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 2));
      ready_span <= $urandom_range(20, 200);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
      default:      out_ready <= ready_span[3];
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [RawW-1:0] d1, input logic [RawW-1:0] d2);
    int gap;
    in_valid <= 1'b1;
    raw_pressure <= d1;
    raw_temperature <= d2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CoefW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic load_coefs(input cfg_t c);
    write_reg(REG_SENS, c.sens_coef);
    write_reg(REG_OFFSET, c.offset_coef);
    write_reg(REG_SENS_TEMP, c.sens_temp_coef);
    write_reg(REG_OFFSET_TEMP, c.offset_temp_coef);
    write_reg(REG_REF_TEMP, c.ref_temp_coef);
    write_reg(REG_TEMP_SLOPE, c.temp_slope_coef);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_requests(input int count);
    logic [RawW-1:0] d1;
    logic [RawW-1:0] d2;
    for (int n = 0; n < count; n++) begin
      d1 = RawW'($urandom);
      if ($urandom_range(0, 9) == 0)
        d1 = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 1) == 0)
        d2 = RawW'($urandom);
      else
        d2 = {sb.coefs.ref_temp_coef, 8'h00} + RawW'($urandom_range(0, 1 << 21))
             - RawW'(1 << 20);
      send_request(d1, d2);
    end
  endtask

  initial begin
    cfg_t c;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset coefficients are all zero.
    send_request('0, '0);
    send_request('1, '1);
    send_request('1, '0);
    send_request('0, '1);
    random_requests(40);
    drain();

    // Typical calibration; reference raw temperature is 6821376.
    c = {16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146};
    load_coefs(c);
    send_request(24'd4311550, 24'd6821376);
    send_request(24'd4311550, 24'd6821375);
    send_request(24'd4311550, 24'd8821376);
    send_request(24'd4311550, 24'd6321376);
    // The next two sit just at and just below the -15.00 C band edge.
    send_request(24'd4311550, 24'd5698446);
    send_request(24'd4311550, 24'd5698445);
    send_request('0, '0);
    send_request('1, '0);
    send_request('0, '1);
    send_request('1, '1);
    send_request(24'hAAAAAA, 24'h555555);
    send_request(24'h555555, 24'hAAAAAA);
    send_request('1, 24'd6821376);
    random_requests(250);
    drain();

    // All coefficients at full scale drive both outputs toward saturation.
    c = '1;
    load_coefs(c);
    send_request('0, '0);
    send_request('1, '0);
    send_request('0, '1);
    send_request('1, '1);
    random_requests(100);
    drain();

    // Writes to unused register indexes must leave the coefficients alone.
    for (int k = int'(REG_TEMP_SLOPE) + 1; k < (1 << IdxW); k++)
      write_reg(k[IdxW-1:0], CoefW'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    random_requests(60);
    drain();

    repeat (4) begin
      c = {$urandom, $urandom, $urandom};
      load_coefs(c);
      random_requests(125);
      drain();
    end

    repeat (LATENCY + 4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- pressure_sensor_temp_compensation_unit.f -----
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_cfg_regs.sv
hw/rtl/ptc_front.sv
hw/rtl/ptc_correct.sv
hw/rtl/ptc_scale.sv
hw/rtl/pressure_sensor_temp_compensation_unit.sv
tb/sv/pressure_sensor_temp_compensation_unit_test.sv
